[sv/linked_list_splice_engine_macros.svh]
// Assertion macros shared by the checker of the splice engine.
`ifndef LINKED_LIST_SPLICE_ENGINE_MACROS_SVH
`define LINKED_LIST_SPLICE_ENGINE_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define LLS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define LLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after any reset cycle.
`define LLS_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

[sv/lls_pkg.sv]
// Package with the constants, types and helper functions of the splice engine.
package lls_pkg;

    localparam int NODE_COUNT = 64;
    localparam int LINE_COUNT = 16;
    localparam int SENT_COUNT = 2 * LINE_COUNT;
    localparam int LINK_DEPTH = NODE_COUNT + SENT_COUNT;
    localparam int LINK_W     = $clog2(LINK_DEPTH);
    localparam int SENT_W     = $clog2(SENT_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT);

    localparam int ACT_W  = 3;
    localparam int NODE_W = 6;
    localparam int LINE_W = 4;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Link table indexes.
    localparam int TBL_NEXT = 0;
    localparam int TBL_PREV = 1;
    localparam int TBL_NUM  = 2;

    typedef logic [LINK_W-1:0] t_link;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_MOVE   = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_RANGE  = 3'd3,
        ACT_LIST   = 3'd4
    } t_action;

    // Command handed from the front end to the sequencer. The field s holds
    // the tail sentinel for an append and the head sentinel for a list walk.
    typedef struct packed {
        t_action op;
        t_link   a;
        t_link   b;
        t_link   c;
        t_link   s;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
        logic              empty;
    } t_result;

    typedef struct packed {
        logic  we;
        t_link waddr;
        t_link wdata;
        t_link raddr;
    } t_tbl_req;

    typedef t_tbl_req [TBL_NUM-1:0] t_link_req;
    typedef t_link    [TBL_NUM-1:0] t_link_data;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP1,
        ST_STEP2,
        ST_STEP3,
        ST_WALK
    } t_back_state;

    function automatic logic is_sentinel(input t_link addr);
        return 32'(addr) >= NODE_COUNT;
    endfunction

    function automatic logic [SENT_W-1:0] sent_idx(input t_link addr);
        return SENT_W'(addr - LINK_W'(NODE_COUNT));
    endfunction

    // Value a sentinel entry holds before it is first written: heads point
    // forward to their tail and back to themselves, tails the other way.
    function automatic t_link sent_reset(input t_link addr, input logic is_next);
        t_link offset;
        logic  is_head;
        offset  = addr - LINK_W'(NODE_COUNT);
        is_head = ~offset[0];
        if (is_next) begin
            return is_head ? addr + LINK_W'(1) : addr;
        end
        return is_head ? addr : addr - LINK_W'(1);
    endfunction

endpackage

[sv/lls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lls_links.sv]
// Next and prev link tables with sentinel reset values and write forwarding.
module lls_links
    import lls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_link_req  i_req,
    output t_link_data o_rdata
);

    for (genvar g = 0; g < TBL_NUM; g++) begin : g_tbl
        t_link                 ram_q;
        logic [SENT_COUNT-1:0] r_valid;
        logic                  r_fwd;
        logic                  r_use_rst;
        t_link                 r_fwd_data;
        t_link                 r_rst_val;
        logic                  n_fwd;
        logic                  n_use_rst;

        lls_ram #(
            .WIDTH (LINK_W),
            .DEPTH (LINK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_req[g].we),
            .i_waddr (i_req[g].waddr),
            .i_wdata (i_req[g].wdata),
            .i_raddr (i_req[g].raddr),
            .o_rdata (ram_q)
        );

        // A read that hits the entry being written this cycle takes the new value.
        assign n_fwd     = i_req[g].we && (i_req[g].waddr == i_req[g].raddr);
        assign n_use_rst = is_sentinel(i_req[g].raddr) && !r_valid[sent_idx(i_req[g].raddr)];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= '0;
            end else if (i_req[g].we && is_sentinel(i_req[g].waddr)) begin
                r_valid[sent_idx(i_req[g].waddr)] <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_fwd      <= n_fwd;
            r_use_rst  <= n_use_rst;
            r_fwd_data <= i_req[g].wdata;
            r_rst_val  <= sent_reset(i_req[g].raddr, g == TBL_NEXT);
        end

        assign o_rdata[g] = r_fwd ? r_fwd_data : (r_use_rst ? r_rst_val : ram_q);
    end

endmodule

[sv/lls_front.sv]
// Front end: checks and classifies incoming words and queues them as commands.
module lls_front
    import lls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [NODE_W-1:0] i_node,
    input  logic [NODE_W-1:0] i_second_node,
    input  logic [NODE_W-1:0] i_target_node,
    input  logic [LINE_W-1:0] i_line,
    input  logic              i_cmd_pop,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd
);

    t_cmd                  r_q [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;

    t_cmd dec_cmd;
    logic dec_ok;
    logic do_push;
    logic do_pop;

    always_comb begin
        logic  node_ok;
        logic  second_ok;
        logic  target_ok;
        logic  line_ok;
        t_link head;
        node_ok   = 32'(i_node) < NODE_COUNT;
        second_ok = 32'(i_second_node) < NODE_COUNT;
        target_ok = 32'(i_target_node) < NODE_COUNT;
        line_ok   = 32'(i_line) < LINE_COUNT;
        head      = LINK_W'(NODE_COUNT + 2 * 32'(i_line));

        dec_cmd.op = t_action'(i_action);
        dec_cmd.a  = LINK_W'(i_node);
        dec_cmd.b  = LINK_W'(i_second_node);
        dec_cmd.c  = LINK_W'(i_target_node);
        dec_cmd.s  = head;
        unique case (i_action)
            ACT_APPEND: begin
                dec_ok    = node_ok && line_ok;
                dec_cmd.s = head + LINK_W'(1);
            end
            ACT_MOVE:   dec_ok = node_ok && second_ok;
            ACT_REMOVE: dec_ok = node_ok;
            ACT_RANGE:  dec_ok = node_ok && second_ok && target_ok;
            ACT_LIST:   dec_ok = line_ok;
            default:    dec_ok = 1'b0;
        endcase
    end

    assign o_full      = r_count == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign o_cmd_valid = r_count != '0;
    assign o_cmd       = r_q[r_rd_ptr];

    // Words that fail the checks are taken and dropped.
    assign do_push = i_push && !o_full && dec_ok;
    assign do_pop  = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == CMDQ_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == CMDQ_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/lls_back.sv]
// Back end: sequencer that carries out link splices and list walks.
module lls_back
    import lls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output t_link_req  o_link_req,
    input  t_link_data i_link_rdata,
    output logic       o_res_push,
    output t_result    o_res,
    input  logic       i_res_full
);

    t_back_state      r_state;
    t_back_state      n_state;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    t_link            r_x;
    t_link            n_x;
    t_link            r_cur;
    t_link            n_cur;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    t_link dn;
    t_link dp;

    assign dn = i_link_rdata[TBL_NEXT];
    assign dp = i_link_rdata[TBL_PREV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_x     <= n_x;
        r_cur   <= n_cur;
        r_count <= n_count;
    end

    always_comb begin
        logic walk_last;
        walk_last  = is_sentinel(dn) || (r_count == CNT_W'(NODE_COUNT - 1));
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_x        = r_x;
        n_cur      = r_cur;
        n_count    = r_count;
        o_cmd_pop  = 1'b0;
        o_link_req = '0;
        o_res_push = 1'b0;
        o_res      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    o_link_req[TBL_NEXT].raddr = (i_cmd.op == ACT_LIST)  ? i_cmd.s :
                                                 (i_cmd.op == ACT_RANGE) ? i_cmd.b : i_cmd.a;
                    o_link_req[TBL_PREV].raddr = (i_cmd.op == ACT_APPEND) ? i_cmd.s : i_cmd.a;
                    n_state = ST_STEP1;
                end
            end

            ST_STEP1: begin
                unique case (r_cmd.op)
                    ACT_APPEND: begin
                        o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: dp, wdata: r_cmd.a, raddr: '0};
                        o_link_req[TBL_PREV] = '{we: 1'b1, waddr: r_cmd.a, wdata: dp, raddr: '0};
                        n_state = ST_STEP2;
                    end
                    ACT_MOVE: begin
                        o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: dp, wdata: dn, raddr: '0};
                        o_link_req[TBL_PREV] = '{we: 1'b1, waddr: dn, wdata: dp, raddr: r_cmd.b};
                        n_state = ST_STEP2;
                    end
                    ACT_REMOVE: begin
                        o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: dp, wdata: dn, raddr: '0};
                        o_link_req[TBL_PREV] = '{we: 1'b1, waddr: dn, wdata: dp, raddr: '0};
                        n_state = ST_IDLE;
                    end
                    ACT_RANGE: begin
                        o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: dp, wdata: dn, raddr: '0};
                        o_link_req[TBL_PREV] = '{we: 1'b1, waddr: dn, wdata: dp, raddr: r_cmd.c};
                        n_state = ST_STEP2;
                    end
                    ACT_LIST: begin
                        if (is_sentinel(dn)) begin
                            if (!i_res_full) begin
                                o_res_push = 1'b1;
                                o_res      = '{node: '0, last: 1'b1, empty: 1'b1};
                                n_state    = ST_IDLE;
                            end else begin
                                o_link_req[TBL_NEXT].raddr = r_cmd.s;
                            end
                        end else begin
                            n_cur   = dn;
                            n_count = '0;
                            o_link_req[TBL_NEXT].raddr = dn;
                            n_state = ST_WALK;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            ST_STEP2: begin
                unique case (r_cmd.op)
                    ACT_APPEND: begin
                        o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: r_cmd.a, wdata: r_cmd.s, raddr: '0};
                        o_link_req[TBL_PREV] = '{we: 1'b1, waddr: r_cmd.s, wdata: r_cmd.a, raddr: '0};
                        n_state = ST_IDLE;
                    end
                    ACT_MOVE: begin
                        o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: dp, wdata: r_cmd.a, raddr: '0};
                        o_link_req[TBL_PREV] = '{we: 1'b1, waddr: r_cmd.a, wdata: dp, raddr: '0};
                        n_state = ST_STEP3;
                    end
                    ACT_RANGE: begin
                        n_x = dp;
                        o_link_req[TBL_PREV] = '{we: 1'b1, waddr: r_cmd.a, wdata: dp, raddr: '0};
                        o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: r_cmd.b, wdata: r_cmd.c, raddr: '0};
                        n_state = ST_STEP3;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            ST_STEP3: begin
                if (r_cmd.op == ACT_MOVE) begin
                    o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: r_cmd.a, wdata: r_cmd.b, raddr: '0};
                    o_link_req[TBL_PREV] = '{we: 1'b1, waddr: r_cmd.b, wdata: r_cmd.a, raddr: '0};
                end else begin
                    o_link_req[TBL_NEXT] = '{we: 1'b1, waddr: r_x, wdata: r_cmd.a, raddr: '0};
                    o_link_req[TBL_PREV] = '{we: 1'b1, waddr: r_cmd.c, wdata: r_cmd.b, raddr: '0};
                end
                n_state = ST_IDLE;
            end

            ST_WALK: begin
                // The next link of the current node is on dn; it and the node count decide the last flag.
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = '{node: NODE_W'(r_cur), last: walk_last, empty: 1'b0};
                    if (walk_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cur   = dn;
                        n_count = r_count + 1'b1;
                        o_link_req[TBL_NEXT].raddr = dn;
                    end
                end else begin
                    o_link_req[TBL_NEXT].raddr = r_cur;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[sv/lls_outq.sv]
// Result queue between the sequencer and the result ports.
module lls_outq
    import lls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_res
);

    t_result               r_q [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == OUTQ_CNT_W'(OUTQ_DEPTH);
    assign o_empty = r_count == '0;
    assign o_res   = r_q[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == OUTQ_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == OUTQ_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/linked_list_splice_engine.sv]
// Linked list splice engine: several doubly linked lists of indexed nodes.
//
// Input words are written like a queue: a word is taken on a clock edge with push
// high and full low. Each word carries one action (append, move before, remove,
// range move or list) and its node and line operands. Words with an index out of
// range or an unknown action are taken and dropped without any effect.
// Results are read like a queue: while empty is low the oldest result word is on
// the output ports, and it leaves on a clock edge with pop high.
// A four-deep command queue decouples the input from the sequencer, and a
// four-deep result queue decouples the sequencer from the reader.
// The sequencer takes a word only when idle; a remove then runs ST_STEP1, an append
// also ST_STEP2, a move and a range move also ST_STEP3, and a list ST_STEP1 and then
// ST_WALK once per node emitted, paced by the single read and single write port of
// each link table. An empty line's word comes from ST_STEP1, the rest from ST_WALK.
// Reset empties both queues and every line; sentinel links read their paired
// values through valid bits, so there is no clearing sweep.
// When the reader stalls, a list walk pauses with the result queue full, and
// once the command queue fills, full rises until the reader drains results.
module linked_list_splice_engine
    import lls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [NODE_W-1:0] i_node,
    input  logic [NODE_W-1:0] i_second_node,
    input  logic [NODE_W-1:0] i_target_node,
    input  logic [LINE_W-1:0] i_line,
    output logic              empty,
    input  logic              pop,
    output logic [NODE_W-1:0] o_out_node,
    output logic              o_is_last,
    output logic              o_is_empty
);

    // Front end to sequencer.
    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_pop;

    // Sequencer to link tables.
    t_link_req  link_req;
    t_link_data link_rdata;

    // Sequencer to result queue.
    logic       res_push;
    t_result    res;
    logic       res_full;
    t_result    out_res;

    // The front end checks each word's operands and turns it into a command
    // with sentinel addresses already worked out.
    lls_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_node        (i_node),
        .i_second_node (i_second_node),
        .i_target_node (i_target_node),
        .i_line        (i_line),
        .i_cmd_pop     (cmd_pop),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd)
    );

    // The sequencer applies the link reads and writes of each command in order
    // and streams list walks into the result queue.
    lls_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_link_req   (link_req),
        .i_link_rdata (link_rdata),
        .o_res_push   (res_push),
        .o_res        (res),
        .i_res_full   (res_full)
    );

    // Next and prev link tables; a read in the same cycle as a write to the
    // same entry returns the written value.
    lls_links u_links (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (link_req),
        .o_rdata (link_rdata)
    );

    lls_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (out_res)
    );

    assign o_out_node = out_res.node;
    assign o_is_last  = out_res.last;
    assign o_is_empty = out_res.empty;

endmodule

[sv/lls_checker.sv]
// Port-level checker for the splice engine and its bind to the top level.
`include "linked_list_splice_engine_macros.svh"

module lls_checker
    import lls_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [NODE_W-1:0] o_out_node,
    input logic              o_is_last,
    input logic              o_is_empty
);

    logic [NODE_W+1:0] res_word;

    assign res_word = {o_out_node, o_is_last, o_is_empty};

    // Reset leaves no result pending and room for input.
    `LLS_ASSERT_RESET(a_reset_clear, empty && !full, "queues not clear after reset")

    // A waiting result word is held until it is popped.
    `LLS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(res_word), "result not held")

    // The empty-line word is the only word of its walk and carries node zero.
    `LLS_ASSERT_IMPL(a_empty_word, !empty && o_is_empty, o_is_last && o_out_node == '0, "bad empty")

    // After a popped word that is not the last of a walk, the next waiting word is no empty-line word.
    `LLS_ASSERT_NEXT(a_walk_cont, pop && !empty && !o_is_last, empty || !o_is_empty, "walk broken")

endmodule

bind linked_list_splice_engine lls_checker u_lls_checker (.*);

[tb/sv/list_walk_checker.sv]
// Checker for the splice engine: mirrors the link tables and compares every walk word.
module list_walk_checker
    import lls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [NODE_W-1:0] i_node,
    input  logic [NODE_W-1:0] i_second_node,
    input  logic [NODE_W-1:0] i_target_node,
    input  logic [LINE_W-1:0] i_line,
    input  logic              empty,
    input  logic              pop,
    input  logic [NODE_W-1:0] i_out_node,
    input  logic              i_is_last,
    input  logic              i_is_empty,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirrored link tables: nodes first, then a head and a tail slot per line.
    t_link   pred_next [LINK_DEPTH];
    t_link   pred_prev [LINK_DEPTH];
    t_result walk_words_due [$];
    int      fail_count = 0;

    function automatic t_link head_slot(input logic [LINE_W-1:0] ln);
        return t_link'(NODE_COUNT + 2 * int'(ln));
    endfunction

    function automatic t_link tail_slot(input logic [LINE_W-1:0] ln);
        return t_link'(NODE_COUNT + 2 * int'(ln) + 1);
    endfunction

    task automatic clear_lines();
        for (int i = 0; i < LINK_DEPTH; i++) begin
            pred_next[i] = '0;
            pred_prev[i] = '0;
        end
        for (int l = 0; l < LINE_COUNT; l++) begin
            pred_next[head_slot(LINE_W'(l))] = tail_slot(LINE_W'(l));
            pred_prev[tail_slot(LINE_W'(l))] = head_slot(LINE_W'(l));
            pred_prev[head_slot(LINE_W'(l))] = head_slot(LINE_W'(l));
            pred_next[tail_slot(LINE_W'(l))] = tail_slot(LINE_W'(l));
        end
    endtask

    task automatic add_due_word(input t_result w);
        walk_words_due.insert(walk_words_due.size(), w);
    endtask

    task automatic unlink(input t_link a);
        t_link p;
        t_link n;
        p = pred_prev[a];
        n = pred_next[a];
        pred_prev[n] = p;
        pred_next[p] = n;
    endtask

    // A walk stops at any sentinel or after NODE_COUNT nodes; an empty line gives
    // one word flagged both last and empty.
    task automatic walk_line(input logic [LINE_W-1:0] ln);
        t_link   cur;
        t_link   nxt;
        t_result word;
        int      count;
        cur   = pred_next[head_slot(ln)];
        count = 0;
        if (int'(cur) >= NODE_COUNT) begin
            word.node  = '0;
            word.last  = 1'b1;
            word.empty = 1'b1;
            add_due_word(word);
        end else begin
            while (int'(cur) < NODE_COUNT && count < NODE_COUNT) begin
                nxt = pred_next[cur];
                count++;
                word.node  = cur[NODE_W-1:0];
                word.last  = (int'(nxt) >= NODE_COUNT) || (count == NODE_COUNT);
                word.empty = 1'b0;
                add_due_word(word);
                cur = nxt;
            end
        end
    endtask

    // Link writes are applied literally and in order, so aliased operands
    // behave exactly as the hardware sequence does.
    task automatic apply_word();
        t_link a;
        t_link b;
        t_link c;
        t_link tl;
        t_link p;
        a = t_link'(i_node);
        b = t_link'(i_second_node);
        c = t_link'(i_target_node);
        case (i_action)
            ACT_APPEND: begin
                tl = tail_slot(i_line);
                p  = pred_prev[tl];
                pred_next[p]  = a;
                pred_prev[a]  = p;
                pred_next[a]  = tl;
                pred_prev[tl] = a;
            end
            ACT_MOVE: begin
                unlink(a);
                pred_next[pred_prev[b]] = a;
                pred_prev[a] = pred_prev[b];
                pred_next[a] = b;
                pred_prev[b] = a;
            end
            ACT_REMOVE: begin
                unlink(a);
            end
            ACT_RANGE: begin
                pred_next[pred_prev[a]] = pred_next[b];
                pred_prev[pred_next[b]] = pred_prev[a];
                pred_prev[a] = pred_prev[c];
                pred_next[b] = c;
                pred_next[pred_prev[c]] = a;
                pred_prev[c] = b;
            end
            ACT_LIST: begin
                walk_line(i_line);
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_walk_word();
        t_result want;
        if (walk_words_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, got out_node %0d is_last %0d is_empty %0d",
                     $time, i_out_node, i_is_last, i_is_empty);
            fail_count++;
        end else begin
            want = walk_words_due.pop_front();
            if (i_out_node !== want.node) begin
                $display("%0t: out_node expected %0d, got %0d", $time, want.node, i_out_node);
                fail_count++;
            end
            if (i_is_last !== want.last) begin
                $display("%0t: is_last expected %0d, got %0d", $time, want.last, i_is_last);
                fail_count++;
            end
            if (i_is_empty !== want.empty) begin
                $display("%0t: is_empty expected %0d, got %0d", $time, want.empty, i_is_empty);
                fail_count++;
            end
        end
    endtask

    // Results are checked before the new word is applied, so a result can never
    // be matched against a walk that was only just accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lines();
            walk_words_due.delete();
        end else begin
            if (pop && !empty) begin
                compare_walk_word();
            end
            if (push && !full) begin
                apply_word();
            end
        end
        o_pending    <= walk_words_due.size();
        o_fail_count <= fail_count;
    end

endmodule

[tb/sv/testbench.sv]
// Top of the splice engine testbench: clock, reset, word traffic, watchdog and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lls_pkg::*;

    // Codes the engine does not define; words carrying them must be dropped.
    localparam logic [ACT_W-1:0] ACT_FIRST_SPARE = 3'd5;
    localparam logic [ACT_W-1:0] ACT_LAST_SPARE  = 3'd7;

    localparam int RESET_CYCLES = 12;
    localparam int PHASE_WORDS  = 62;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [ACT_W-1:0]  i_action;
    logic [NODE_W-1:0] i_node;
    logic [NODE_W-1:0] i_second_node;
    logic [NODE_W-1:0] i_target_node;
    logic [LINE_W-1:0] i_line;
    logic              empty;
    logic              pop;
    logic [NODE_W-1:0] o_out_node;
    logic              o_is_last;
    logic              o_is_empty;

    int fail_count;
    int pending;

    // Idle rates in percent per cycle, set by the phase and read by both sides.
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_go;

    // Stimulus bookkeeping. A node whose links were never written must never be
    // read by the engine, so moves, removes and range moves only ever name nodes
    // that have been appended at least once. The loose set holds nodes that are
    // probably in no line, which keeps most appends well formed.
    bit [NODE_COUNT-1:0] linked_ever;
    bit [NODE_COUNT-1:0] loose;

    linked_list_splice_engine dut (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_action,
        .i_node,
        .i_second_node,
        .i_target_node,
        .i_line,
        .empty,
        .pop,
        .o_out_node,
        .o_is_last,
        .o_is_empty
    );

    list_walk_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_node        (i_node),
        .i_second_node (i_second_node),
        .i_target_node (i_target_node),
        .i_line        (i_line),
        .empty         (empty),
        .pop           (pop),
        .i_out_node    (o_out_node),
        .i_is_last     (o_is_last),
        .i_is_empty    (o_is_empty),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Reset is held once, at the start, and released on a falling edge.
    initial begin
        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Reader side. It pops at random according to the phase, except for one
    // long hold-off in the last phase, counted here, during which the writer keeps
    // offering words until both internal queues fill and full rises.
    initial begin
        int held;
        pop  = 1'b0;
        held = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_go && held < HOLD_CYCLES) begin
                pop <= 1'b0;
                held++;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // Offers one word after a random idle gap and returns once it is taken.
    // Push is lowered here only on a gap, so back-to-back words keep it high.
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] a_n,
                             input logic [NODE_W-1:0] b_n, input logic [NODE_W-1:0] c_n,
                             input logic [LINE_W-1:0] ln);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push          <= 1'b1;
        i_action      <= act;
        i_node        <= a_n;
        i_second_node <= b_n;
        i_target_node <= c_n;
        i_line        <= ln;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (act == ACT_APPEND) begin
            linked_ever[a_n] = 1'b1;
            loose[a_n]       = 1'b0;
        end else if (act == ACT_REMOVE) begin
            loose[a_n] = 1'b1;
        end
    endtask

    // Stops offering words until every expected walk word has been read.
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Phase settings change just after a rising edge, away from the falling
    // edge at which both sides read them.
    task automatic enter_phase(input int tx_pct, input int rx_pct);
        @(posedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    function automatic logic [NODE_W-1:0] any_linked();
        logic [NODE_W-1:0] n;
        n = NODE_W'($urandom);
        while (!linked_ever[n]) n = NODE_W'($urandom);
        return n;
    endfunction

    function automatic logic [NODE_W-1:0] pick_fresh();
        logic [NODE_W-1:0] n;
        n = NODE_W'($urandom);
        if (loose != '0 && $urandom_range(99) < 80) begin
            while (!loose[n]) n = NODE_W'($urandom);
        end
        return n;
    endfunction

    // Most traffic goes to a few lines so that the lists grow long enough for
    // walks and splices to mean something; the rest spreads over all lines.
    function automatic logic [LINE_W-1:0] pick_line();
        if ($urandom_range(99) < 70) begin
            return LINE_W'($urandom_range(3));
        end
        return LINE_W'($urandom_range(LINE_COUNT - 1));
    endfunction

    // Random words with random content in every field, ignored fields included.
    // Range moves name a single node half of the time, which keeps the run well
    // formed more often. Words with spare codes do not count toward the total.
    task automatic random_phase(input int words);
        int                counted;
        int                roll;
        logic [NODE_W-1:0] a_n;
        logic [NODE_W-1:0] b_n;
        logic [NODE_W-1:0] c_n;
        logic [LINE_W-1:0] ln;
        counted = 0;
        while (counted < words) begin
            roll = $urandom_range(99);
            a_n  = any_linked();
            b_n  = any_linked();
            c_n  = any_linked();
            ln   = pick_line();
            if (roll < 28) begin
                send_word(ACT_APPEND, pick_fresh(), NODE_W'($urandom), NODE_W'($urandom), ln);
            end else if (roll < 43) begin
                send_word(ACT_MOVE, a_n, b_n, NODE_W'($urandom), LINE_W'($urandom));
            end else if (roll < 53) begin
                send_word(ACT_REMOVE, a_n, NODE_W'($urandom), NODE_W'($urandom),
                          LINE_W'($urandom));
            end else if (roll < 68) begin
                send_word(ACT_RANGE, a_n, ($urandom_range(1) == 0) ? a_n : b_n, c_n,
                          LINE_W'($urandom));
            end else if (roll < 95) begin
                send_word(ACT_LIST, NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom), ln);
            end else begin
                send_word(ACT_W'($urandom_range(ACT_LAST_SPARE, ACT_FIRST_SPARE)),
                          NODE_W'($urandom), NODE_W'($urandom), NODE_W'($urandom),
                          LINE_W'($urandom));
            end
            if (roll < 95) counted++;
        end
    endtask

    initial begin
        push          = 1'b0;
        i_action      = '0;
        i_node        = '0;
        i_second_node = '0;
        i_target_node = '0;
        i_line        = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_go       = 1'b0;
        linked_ever   = '0;
        loose         = '1;
        wait (i_rst_n === 1'b1);

        // First phase: the writer seldom idles, the reader mostly does.
        enter_phase(11, 88);

        // Directed words. A walk of a line that was never touched yields the
        // single empty word.
        send_word(ACT_LIST, '0, '0, '0, '0);
        // Build line 0 and put the highest node on the highest line.
        send_word(ACT_APPEND, '0, '0, '0, '0);
        send_word(ACT_APPEND, '1, '0, '0, '1);
        send_word(ACT_APPEND, 6'd5, '0, '0, '0);
        send_word(ACT_APPEND, 6'd9, '0, '0, '0);
        send_word(ACT_LIST, '0, '0, '0, '0);
        send_word(ACT_LIST, '0, '0, '0, '1);
        // Move the back node to the front of its own line.
        send_word(ACT_MOVE, 6'd9, 6'd0, '0, '0);
        // Splice the run 0..5 of line 0 in front of node 21 on line 3.
        send_word(ACT_APPEND, 6'd20, '0, '0, 4'd3);
        send_word(ACT_APPEND, 6'd21, '0, '0, 4'd3);
        send_word(ACT_RANGE, 6'd0, 6'd5, 6'd21, '0);
        send_word(ACT_LIST, '0, '0, '0, 4'd3);
        send_word(ACT_LIST, '0, '0, '0, '0);
        send_word(ACT_REMOVE, 6'd0, '0, '0, '0);
        send_word(ACT_LIST, '0, '0, '0, 4'd3);
        // Spare codes with every operand bit set or cleared: no effect.
        send_word(ACT_FIRST_SPARE, '1, '1, '1, '1);
        send_word(ACT_W'(ACT_FIRST_SPARE + 1), '0, '0, '0, '0);
        send_word(ACT_LAST_SPARE, '1, '1, '1, '1);
        // Append a node that is still linked on another line; it is not
        // unlinked first, so line 15 now runs into the tail of line 0.
        send_word(ACT_APPEND, '1, '0, '0, '0);
        send_word(ACT_LIST, '0, '0, '0, '0);
        send_word(ACT_LIST, '0, '0, '0, '1);
        // Move a node in front of itself: it ends up pointing at itself, and
        // the walk of line 0 runs the full node count before it stops.
        send_word(ACT_MOVE, 6'd9, 6'd9, '0, '0);
        send_word(ACT_LIST, '0, '0, '0, '0);
        // Empty line with every ignored operand bit set.
        send_word(ACT_LIST, '1, '1, '1, 4'd7);

        random_phase(PHASE_WORDS);
        wait_drained();

        // Second phase: the writer mostly idles, the reader seldom does.
        enter_phase(88, 11);
        random_phase(PHASE_WORDS);
        wait_drained();

        // Last phase: no idling, with the reader's long hold-off at the start.
        enter_phase(0, 0);
        hold_go = 1'b1;
        random_phase(PHASE_WORDS + 1);
        wait_drained();

        // Let any word that yields no result finish inside the engine.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
